FILE: hw/rtl/particle_code_classifier_assert.svh
// Assertion macros of the particle code classifier RTL.
`ifndef PARTICLE_CODE_CLASSIFIER_ASSERT_SVH
`define PARTICLE_CODE_CLASSIFIER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PCC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("particle code classifier: check failed");

// Current condition needs a given condition to have held earlier, as far back as the depth argument.
`define PCC_ASSERT_PAST(lbl, cur, prior, depth) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cur) |-> $past(prior, depth)) \
    else $error("particle code classifier: result without matching request");

`endif

FILE: hw/rtl/pcc_pkg.sv
// Shared types, constants and lookup functions of the particle code classifier.
package pcc_pkg;

  // Pipeline depth from request to result strobe.
  localparam int PipeDepth = 12;

  // Decimal split constants.
  localparam logic [23:0] ExtraDiv = 24'd10000000;
  localparam logic [13:0] LowDiv   = 14'd10000;
  localparam logic [63:0] RecipExtraFull = (64'd1 << 40) / 64'd10000000;
  localparam logic [63:0] RecipLowFull   = (64'd1 << 40) / 64'd10000;
  localparam logic [16:0] RecipExtra = RecipExtraFull[16:0];
  localparam logic [26:0] RecipLow   = RecipLowFull[26:0];
  localparam logic [15:0] Div10Mul   = 16'd52429;

  // Special codes.
  localparam logic [13:0] MesonKLong  = 14'd130;
  localparam logic [13:0] MesonKShort = 14'd310;
  localparam logic [13:0] FundMax     = 14'd100;
  localparam logic [13:0] LeptonLo    = 14'd11;
  localparam logic [13:0] LeptonHi    = 14'd18;

  // Extra digit values.
  localparam logic [7:0] ExtraValidLo = 8'd45;
  localparam logic [7:0] ExtraQ3Hi    = 8'd46;
  localparam logic [7:0] ExtraQ6A     = 8'd47;
  localparam logic [7:0] ExtraNeutral = 8'd48;
  localparam logic [7:0] ExtraQ6B     = 8'd49;
  localparam logic [7:0] ExtraValidHi = 8'd50;

  // Tentative digit that disables the meson spin codes.
  localparam logic [3:0] TentExcluded = 4'd9;

  // Bit positions of class_flags.
  localparam int FlagValid   = 0;
  localparam int FlagMeson   = 1;
  localparam int FlagBaryon  = 2;
  localparam int FlagDiquark = 3;
  localparam int FlagHadron  = 4;
  localparam int FlagLepton  = 5;
  localparam int FlagNucleus = 6;
  localparam int FlagQuarks  = 7;

  typedef struct packed {
    logic [9:0] q;
    logic [3:0] r;
  } div10_t;

  typedef struct packed {
    logic        neg;
    logic [7:0]  extra;
    logic [9:0]  hi3;
    logic [13:0] low4;
  } split_t;

  typedef struct packed {
    logic        neg;
    logic [7:0]  extra;
    logic [13:0] low4;
    logic [3:0]  nj;
    logic [3:0]  q3;
    logic [3:0]  q2;
    logic [3:0]  q1;
    logic [3:0]  nl;
    logic [3:0]  nr;
    logic [3:0]  tent;
  } digits_t;

  // Quotient and remainder by ten, exact for values below 10000.
  function automatic div10_t div10(input logic [13:0] x);
    logic [29:0] prod;
    logic [13:0] back;
    div10_t      res;
    prod  = 30'(x) * 30'(Div10Mul);
    res.q = prod[28:19];
    back  = 14'(res.q) * 14'd10;
    res.r = 4'(x - back);
    return res;
  endfunction

  // Three times the charge of table entry idx.
  function automatic logic signed [3:0] charge_of(input logic [6:0] idx);
    logic signed [3:0] c;
    case (idx)
      7'd0, 7'd2, 7'd4, 7'd6, 7'd41: c = -4'sd1;
      7'd1, 7'd3, 7'd5, 7'd7:        c = 4'sd2;
      7'd10, 7'd12, 7'd14, 7'd16:    c = -4'sd3;
      7'd23, 7'd33, 7'd36, 7'd52:    c = 4'sd3;
      7'd51, 7'd53:                  c = 4'sd6;
      default:                       c = 4'sd0;
    endcase
    return c;
  endfunction

  // Three times the charge of one quark digit; zero is neutral.
  function automatic logic signed [3:0] quark_charge(input logic [3:0] d);
    logic signed [3:0] c;
    if (d == 4'd0) begin
      c = 4'sd0;
    end else begin
      c = charge_of(7'(d) - 7'd1);
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/pcc_range_split.sv
// Magnitude and decimal range split: extra digits, upper three and lower four digits.
module pcc_range_split import pcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] code,
  output logic               out_valid,
  output split_t             out_data
);

  logic [6:0]  vld;
  logic        neg1, neg2, neg3, neg4, neg5, neg6;
  logic [31:0] mag1, mag2;
  logic [7:0]  ext_est2, ext_est3;
  logic [24:0] rem3;
  logic [7:0]  extra4, extra5, extra6;
  logic [23:0] rest4, rest5;
  logic [9:0]  hi_est5, hi_est6;
  logic [14:0] rem6;

  logic [31:0] code_u;
  logic [47:0] ext_prod;
  logic [31:0] ext_back;
  logic        ext_fix;
  logic [49:0] low_prod;
  logic [23:0] low_back;
  logic        low_fix;

  assign code_u   = code;
  assign ext_prod = 48'(mag1) * 48'(RecipExtra);
  assign ext_back = 32'(ext_est2) * 32'(ExtraDiv);
  assign ext_fix  = rem3 >= 25'(ExtraDiv);
  assign low_prod = 50'(rest4) * 50'(RecipLow);
  assign low_back = 24'(hi_est5) * 24'(LowDiv);
  assign low_fix  = rem6 >= 15'(LowDiv);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // magnitude
    neg1 <= code_u[31];
    mag1 <= code_u[31] ? (~code_u + 32'd1) : code_u;
    // estimate of the extra digits, exact or one short
    neg2     <= neg1;
    mag2     <= mag1;
    ext_est2 <= ext_prod[47:40];
    neg3     <= neg2;
    ext_est3 <= ext_est2;
    rem3     <= 25'(mag2 - ext_back);
    // correct the estimate
    neg4   <= neg3;
    extra4 <= ext_fix ? (ext_est3 + 8'd1) : ext_est3;
    rest4  <= ext_fix ? 24'(rem3 - 25'(ExtraDiv)) : rem3[23:0];
    // same scheme for the split at ten thousand
    neg5    <= neg4;
    extra5  <= extra4;
    rest5   <= rest4;
    hi_est5 <= low_prod[49:40];
    neg6    <= neg5;
    extra6  <= extra5;
    hi_est6 <= hi_est5;
    rem6    <= 15'(rest5 - low_back);
    out_data.neg   <= neg6;
    out_data.extra <= extra6;
    out_data.hi3   <= low_fix ? (hi_est6 + 10'd1) : hi_est6;
    out_data.low4  <= low_fix ? 14'(rem6 - 15'(LowDiv)) : rem6[13:0];
  end

  assign out_valid = vld[6];

endmodule

FILE: hw/rtl/pcc_digit_split.sv
// Decimal digit extraction of the upper and lower groups by repeated division by ten.
module pcc_digit_split import pcc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  split_t  in_data,
  output logic    out_valid,
  output digits_t out_data
);

  logic [2:0]  vld;
  logic        a_neg, b_neg;
  logic [7:0]  a_extra, b_extra;
  logic [13:0] a_low4, b_low4;
  logic [9:0]  a_lq, a_hq, b_lq;
  logic [3:0]  a_nj, a_nl, b_nj, b_nl, b_q3, b_nr, b_tent;

  div10_t dl0, dh0, dl1, dh1, dl2;

  assign dl0 = div10(in_data.low4);
  assign dh0 = div10({4'd0, in_data.hi3});
  assign dl1 = div10({4'd0, a_lq});
  assign dh1 = div10({4'd0, a_hq});
  assign dl2 = div10({4'd0, b_lq});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    a_neg   <= in_data.neg;
    a_extra <= in_data.extra;
    a_low4  <= in_data.low4;
    a_lq    <= dl0.q;
    a_hq    <= dh0.q;
    a_nj    <= dl0.r;
    a_nl    <= dh0.r;

    b_neg   <= a_neg;
    b_extra <= a_extra;
    b_low4  <= a_low4;
    b_lq    <= dl1.q;
    b_nj    <= a_nj;
    b_nl    <= a_nl;
    b_q3    <= dl1.r;
    b_nr    <= dh1.r;
    // upper group is below a thousand, so the quotient is the last digit
    b_tent  <= dh1.q[3:0];

    out_data.neg   <= b_neg;
    out_data.extra <= b_extra;
    out_data.low4  <= b_low4;
    out_data.nj    <= b_nj;
    out_data.q3    <= b_q3;
    out_data.q2    <= dl2.r;
    out_data.q1    <= dl2.q[3:0];
    out_data.nl    <= b_nl;
    out_data.nr    <= b_nr;
    out_data.tent  <= b_tent;
  end

  assign out_valid = vld[2];

endmodule

FILE: hw/rtl/pcc_classify.sv
// Classification, quark content, charge and spin codes from the decimal digits.
module pcc_classify import pcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  digits_t           dig,
  output logic              out_valid,
  output logic [7:0]        class_flags,
  output logic [5:0]        quark_mask,
  output logic signed [3:0] three_charge,
  output logic [3:0]        total_spin_code,
  output logic              spin_code,
  output logic [2:0]        orbital_code,
  output logic [13:0]       fundamental_number,
  output logic [7:0]        extra_digits
);

  // first stage registers
  logic              a_v;
  logic [7:0]        a_extra;
  logic [13:0]       a_fund;
  logic              a_fund_small, a_quarks, a_meson, a_baryon, a_diquark;
  logic [5:0]        a_qmask;
  logic signed [4:0] a_pre;
  logic              a_flip;
  logic [3:0]        a_nj, a_nl, a_tent;

  // first stage logic
  logic              ext_zero, hi_zero, special;
  logic [13:0]       fund_c;
  logic              fund_small_c, quarks_c, meson_c, baryon_c, diquark_c;
  logic [5:0]        qmask_c;
  logic signed [3:0] c1, c2, c3, cf;
  logic signed [4:0] s1, s2, s3, sf, pre_c;
  logic              flip_c;

  // second stage logic
  logic              ext_zero_b;
  logic [7:0]        flags_c;
  logic signed [4:0] chg_c;
  logic              scode_c;
  logic [2:0]        lcode_c, step_c;

  always_comb begin
    ext_zero     = dig.extra == 8'd0;
    hi_zero      = (dig.nl | dig.nr | dig.tent) == 4'd0;
    fund_c       = (dig.q2 == 4'd0 && dig.q1 == 4'd0) ? dig.low4 : 14'd0;
    fund_small_c = fund_c != 14'd0 && fund_c <= FundMax;
    quarks_c     = ext_zero && (!hi_zero || dig.low4 > FundMax) && !fund_small_c;
    special      = ext_zero && hi_zero && (dig.low4 inside {MesonKLong, MesonKShort});

    meson_c   = quarks_c && (special ||
                (dig.nj != 4'd0 && dig.q3 != 4'd0 && dig.q2 != 4'd0 && dig.q1 == 4'd0 &&
                 !(dig.q3 == dig.q2 && dig.neg)));
    baryon_c  = quarks_c && dig.nj != 4'd0 && dig.q3 != 4'd0 && dig.q2 != 4'd0 &&
                dig.q1 != 4'd0;
    diquark_c = quarks_c && dig.nj != 4'd0 && dig.q3 == 4'd0 && dig.q2 != 4'd0 &&
                dig.q1 != 4'd0 && !(dig.nj == 4'd1 && dig.q2 == dig.q1);

    for (int i = 0; i < 6; i++) begin
      qmask_c[i] = quarks_c && (dig.q1 == 4'(i + 1) || dig.q2 == 4'(i + 1) ||
                                dig.q3 == 4'(i + 1));
    end

    c1 = quark_charge(dig.q1);
    c2 = quark_charge(dig.q2);
    c3 = quark_charge(dig.q3);
    cf = charge_of(7'(fund_c - 14'd1));
    s1 = {c1[3], c1};
    s2 = {c2[3], c2};
    s3 = {c3[3], c3};
    sf = {cf[3], cf};

    pre_c  = 5'sd0;
    flip_c = 1'b0;
    if (!ext_zero) begin
      // ions carry no sign
      if (dig.extra inside {ExtraValidLo, ExtraQ3Hi}) begin
        pre_c = 5'sd3;
      end else if (dig.extra inside {ExtraQ6A, ExtraQ6B}) begin
        pre_c = 5'sd6;
      end
    end else if (dig.nj != 4'd0) begin
      flip_c = dig.neg;
      if (fund_small_c) begin
        pre_c = sf;
      end else if (dig.q1 == 4'd0) begin
        if (dig.q2 inside {4'd3, 4'd5}) begin
          pre_c = s3 - s2;
        end else begin
          pre_c = s2 - s3;
        end
      end else if (dig.q3 == 4'd0) begin
        pre_c = s2 + s1;
      end else begin
        pre_c = s3 + s2 + s1;
      end
    end
  end

  always_comb begin
    ext_zero_b = a_extra == 8'd0;

    flags_c = '0;
    flags_c[FlagValid]   = ext_zero_b ? (a_meson || a_baryon || a_diquark || a_fund != 14'd0)
                                      : (a_extra inside {[ExtraValidLo:ExtraValidHi]});
    flags_c[FlagMeson]   = a_meson;
    flags_c[FlagBaryon]  = a_baryon;
    flags_c[FlagDiquark] = a_diquark;
    flags_c[FlagHadron]  = ext_zero_b && (a_meson || a_baryon);
    flags_c[FlagLepton]  = ext_zero_b && (a_fund inside {[LeptonLo:LeptonHi]});
    flags_c[FlagNucleus] = !ext_zero_b && !(a_extra inside {ExtraNeutral, ExtraValidHi});
    flags_c[FlagQuarks]  = a_quarks;

    chg_c = a_flip ? (5'sd0 - a_pre) : a_pre;

    scode_c = 1'b0;
    lcode_c = 3'd0;
    step_c  = 3'(a_nj[3:1]) - 3'd1;
    if (a_meson && a_tent != TentExcluded) begin
      scode_c = ((a_nl inside {4'd0, 4'd2, 4'd3}) && a_nj >= 4'd3) ||
                (a_nl == 4'd1 && a_nj == 4'd1);
      if (a_nj inside {4'd3, 4'd5, 4'd7, 4'd9}) begin
        if (a_nl == 4'd0) begin
          lcode_c = step_c;
        end else if (a_nl inside {4'd1, 4'd2}) begin
          lcode_c = step_c + 3'd1;
        end else if (a_nl == 4'd3) begin
          lcode_c = step_c + 3'd2;
        end
      end else if (a_nj == 4'd1 && a_nl == 4'd1) begin
        lcode_c = 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_v       <= in_valid;
      out_valid <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    a_extra      <= dig.extra;
    a_fund       <= fund_c;
    a_fund_small <= fund_small_c;
    a_quarks     <= quarks_c;
    a_meson      <= meson_c;
    a_baryon     <= baryon_c;
    a_diquark    <= diquark_c;
    a_qmask      <= qmask_c;
    a_pre        <= pre_c;
    a_flip       <= flip_c;
    a_nj         <= dig.nj;
    a_nl         <= dig.nl;
    a_tent       <= dig.tent;

    class_flags        <= flags_c;
    quark_mask         <= a_qmask;
    three_charge       <= chg_c[3:0];
    total_spin_code    <= (a_fund_small || !ext_zero_b) ? 4'd0 : a_nj;
    spin_code          <= scode_c;
    orbital_code       <= lcode_c;
    fundamental_number <= a_fund;
    extra_digits       <= a_extra;
  end

endmodule

FILE: hw/rtl/particle_code_classifier.sv
// Top level of the particle code classifier pipeline.
//
// Usage:
//   Drive particle_code and raise start for one cycle per request. busy is
//   always low, so a request is taken on every cycle that start is high,
//   back to back with no gaps.
//   Each request yields one result: done pulses for one cycle with
//   class_flags, quark_mask, three_charge, total_spin_code, spin_code,
//   orbital_code, fundamental_number and extra_digits valid alongside it.
//   Throughput is one request per cycle, and results leave in request
//   order. The pipeline holds one magnitude stage, then a reciprocal
//   multiply, back-multiply and correction for each of the two range
//   splits, then three divide-by-ten stages, then two classification
//   stages.
//   The receiver has no way to stall, so results must be taken as they
//   appear. A synchronous reset drops every request in flight and no
//   result strobe follows for those requests.
`include "particle_code_classifier_assert.svh"

module particle_code_classifier import pcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] particle_code,
  output logic               done,
  output logic [7:0]         class_flags,
  output logic [5:0]         quark_mask,
  output logic signed [3:0]  three_charge,
  output logic [3:0]         total_spin_code,
  output logic               spin_code,
  output logic [2:0]         orbital_code,
  output logic [13:0]        fundamental_number,
  output logic [7:0]         extra_digits
);

  logic    accept;
  logic    split_valid, digit_valid;
  split_t  split_data;
  digits_t digit_data;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  pcc_range_split u_range_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .code      (particle_code),
    .out_valid (split_valid),
    .out_data  (split_data)
  );

  pcc_digit_split u_digit_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .in_data   (split_data),
    .out_valid (digit_valid),
    .out_data  (digit_data)
  );

  pcc_classify u_classify (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (digit_valid),
    .dig                (digit_data),
    .out_valid          (done),
    .class_flags        (class_flags),
    .quark_mask         (quark_mask),
    .three_charge       (three_charge),
    .total_spin_code    (total_spin_code),
    .spin_code          (spin_code),
    .orbital_code       (orbital_code),
    .fundamental_number (fundamental_number),
    .extra_digits       (extra_digits)
  );

  `PCC_ASSERT_PAST(a_done_follows_request, done, start && !busy, PipeDepth)
  `PCC_ASSERT_IMPL(a_hadron_kind, done && class_flags[FlagHadron], class_flags[FlagMeson] || class_flags[FlagBaryon])
  `PCC_ASSERT_IMPL(a_nonmeson_codes, done && !class_flags[FlagMeson], spin_code == 1'b0 && orbital_code == 3'd0)
  `PCC_ASSERT_IMPL(a_nucleus_extra, done && class_flags[FlagNucleus], extra_digits != 8'd0)
  `PCC_ASSERT_IMPL(a_mask_needs_quarks, done && !class_flags[FlagQuarks], quark_mask == 6'd0)

endmodule

FILE: tb/tb_particle_code_classifier.sv
// Self-checking testbench of the particle code classifier.
`timescale 1ns / 100ps

module tb_particle_code_classifier;
  import pcc_pkg::*;

  localparam int RandomRequests = 1250;
  localparam int FlushCycles    = PipeDepth + 8;
  localparam int DrainLimit     = 2000;

  typedef struct packed {
    logic [7:0]        flags;
    logic [5:0]        qmask;
    logic signed [3:0] charge;
    logic [3:0]        jcode;
    logic              scode;
    logic [2:0]        lcode;
    logic [13:0]       fund;
    logic [7:0]        extra;
  } decode_t;

  typedef struct {
    logic [31:0] code;
    bit          known;
    decode_t     res;
  } directed_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [31:0] particle_code;
  logic               done;
  logic [7:0]         class_flags;
  logic [5:0]         quark_mask;
  logic signed [3:0]  three_charge;
  logic [3:0]         total_spin_code;
  logic               spin_code;
  logic [2:0]         orbital_code;
  logic [13:0]        fundamental_number;
  logic [7:0]         extra_digits;

  decode_t       decode_q[$];
  directed_row_t directed_rows[$];
  int            errors;
  int            requests_sent;
  int            results_checked;
  int            hadrons_seen;
  int            nuclei_seen;
  int            leptons_seen;

  particle_code_classifier DUT (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .particle_code      (particle_code),
    .done               (done),
    .class_flags        (class_flags),
    .quark_mask         (quark_mask),
    .three_charge       (three_charge),
    .total_spin_code    (total_spin_code),
    .spin_code          (spin_code),
    .orbital_code       (orbital_code),
    .fundamental_number (fundamental_number),
    .extra_digits       (extra_digits)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Three times the charge of a fundamental code 1..100.
  function automatic int fund_charge(input int unsigned code);
    int c;
    case (code)
      1, 3, 5, 7, 42: c = -1;
      2, 4, 6, 8:     c = 2;
      11, 13, 15, 17: c = -3;
      24, 34, 37, 53: c = 3;
      52, 54:         c = 6;
      default:        c = 0;
    endcase
    return c;
  endfunction

  function automatic int digit_charge(input int unsigned d);
    return (d == 0) ? 0 : fund_charge(d);
  endfunction

  function automatic decode_t decode_code(input logic [31:0] raw);
    bit          neg;
    int unsigned mag, nj, q3, q2, q1, nl, tent, extra, fund, step;
    bit          fund_small, quarks, meson, baryon, diquark;
    bit          valid, hadron, lepton, nucleus;
    int          chg;
    decode_t     r;
    neg   = raw[31];
    mag   = neg ? (32'd0 - raw) : raw;
    nj    = mag % 10;
    q3    = (mag / 10) % 10;
    q2    = (mag / 100) % 10;
    q1    = (mag / 1000) % 10;
    nl    = (mag / 10000) % 10;
    tent  = (mag / 1000000) % 10;
    extra = mag / 10000000;
    fund  = (q2 == 0 && q1 == 0) ? (mag % 10000) : 0;
    fund_small = fund > 0 && fund <= 100;

    quarks  = extra == 0 && mag > 100 && !fund_small;
    meson   = 1'b0;
    baryon  = 1'b0;
    diquark = 1'b0;
    if (quarks) begin
      if (mag == 130 || mag == 310) begin
        meson = 1'b1;
      end else if (nj > 0 && q3 > 0 && q2 > 0 && q1 == 0) begin
        meson = !(q3 == q2 && neg);
      end
      baryon  = nj > 0 && q3 > 0 && q2 > 0 && q1 > 0;
      diquark = nj > 0 && q3 == 0 && q2 > 0 && q1 > 0 && !(nj == 1 && q2 == q1);
    end
    valid   = (extra > 0) ? (extra >= 45 && extra <= 50) : (meson || baryon || diquark || fund > 0);
    hadron  = extra == 0 && (meson || baryon);
    lepton  = extra == 0 && fund >= 11 && fund <= 18;
    nucleus = extra > 0 && extra != 48 && extra != 50;

    r = '0;
    r.flags[FlagValid]   = valid;
    r.flags[FlagMeson]   = meson;
    r.flags[FlagBaryon]  = baryon;
    r.flags[FlagDiquark] = diquark;
    r.flags[FlagHadron]  = hadron;
    r.flags[FlagLepton]  = lepton;
    r.flags[FlagNucleus] = nucleus;
    r.flags[FlagQuarks]  = quarks;

    if (quarks) begin
      for (int q = 1; q <= 6; q++) begin
        if (q1 == q || q2 == q || q3 == q) r.qmask[q-1] = 1'b1;
      end
    end

    chg = 0;
    if (raw == 32'd0) begin
      chg = 0;
    end else if (extra > 0) begin
      if (extra == 45 || extra == 46) chg = 3;
      else if (extra == 47 || extra == 49) chg = 6;
    end else if (nj != 0) begin
      if (fund_small) begin
        chg = fund_charge(fund);
      end else if (q1 == 0) begin
        // strange and bottom mesons flip the quark order
        if (q2 == 3 || q2 == 5) chg = digit_charge(q3) - digit_charge(q2);
        else chg = digit_charge(q2) - digit_charge(q3);
      end else if (q3 == 0) begin
        chg = digit_charge(q2) + digit_charge(q1);
      end else begin
        chg = digit_charge(q3) + digit_charge(q2) + digit_charge(q1);
      end
      if (neg) chg = -chg;
    end
    r.charge = 4'(chg);
    r.jcode  = (fund_small || extra > 0) ? 4'd0 : 4'(nj);

    if (meson && tent != 9) begin
      if ((nl == 0 || nl == 2 || nl == 3) && nj >= 3) r.scode = 1'b1;
      else if (nl == 1 && nj == 1) r.scode = 1'b1;
      if (nj == 3 || nj == 5 || nj == 7 || nj == 9) begin
        step = (nj - 3) / 2;
        if (nl == 0) r.lcode = 3'(step);
        else if (nl == 1 || nl == 2) r.lcode = 3'(step + 1);
        else if (nl == 3) r.lcode = 3'(step + 2);
      end else if (nj == 1 && nl == 1) begin
        r.lcode = 3'd1;
      end
    end
    r.fund  = 14'(fund);
    r.extra = 8'(extra);
    return r;
  endfunction

  function automatic logic [31:0] random_code();
    int unsigned sel, mag, extra;
    logic [31:0] raw;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      return $urandom();
    end else if (sel < 35) begin
      mag = $urandom_range(0, 1000);
    end else if (sel < 75) begin
      // well-formed hadron-like digit string
      mag = $urandom_range(0, 9) + 10 * $urandom_range(0, 6) + 100 * $urandom_range(0, 6)
          + 1000 * (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 6));
      if ($urandom_range(0, 1) == 0) mag += 10000 * $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) mag += 100000 * $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) mag += 1000000 * $urandom_range(0, 9);
    end else if (sel < 90) begin
      extra = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 213) : $urandom_range(40, 56);
      mag   = extra * 10000000 + $urandom_range(0, 9999999);
    end else begin
      case ($urandom_range(0, 5))
        0: mag = 32'h7FFF_FFFF - $urandom_range(0, 20);
        1: mag = 9999999 - $urandom_range(0, 20);
        2: mag = 10000000 + $urandom_range(0, 20);
        3: mag = 90 + $urandom_range(0, 20);
        4: mag = 0;
        default: return 32'h8000_0000;
      endcase
    end
    raw = ($urandom_range(0, 1) == 0) ? mag : (32'd0 - mag);
    return raw;
  endfunction

  task automatic add_known(input logic [31:0] code, input logic [7:0] flags,
                           input logic signed [3:0] charge, input logic [13:0] fund,
                           input logic [7:0] extra);
    directed_row_t row;
    row.code   = code;
    row.known  = 1'b1;
    row.res    = '0;
    row.res.flags  = flags;
    row.res.charge = charge;
    row.res.fund   = fund;
    row.res.extra  = extra;
    directed_rows.push_back(row);
  endtask

  task automatic add_predicted(input logic [31:0] code);
    directed_row_t row;
    row.code  = code;
    row.known = 1'b0;
    row.res   = decode_code(code);
    directed_rows.push_back(row);
  endtask

  // Hold the request until it is taken, then log what it should produce.
  task automatic issue(input logic [31:0] code, input decode_t res);
    @(negedge clk);
    start         <= 1'b1;
    particle_code <= code;
    @(posedge clk);
    while (busy) @(posedge clk);
    decode_q.push_back(res);
    requests_sent++;
  endtask

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      start         <= 1'b0;
      particle_code <= $urandom();
    end
  endtask

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : score
    decode_t want;
    if (!rst && done) begin
      if (decode_q.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual flags %0h",
                 $time, class_flags);
        errors++;
      end else begin
        want = decode_q.pop_front();
        compare_field("class_flags", want.flags, class_flags);
        compare_field("quark_mask", want.qmask, quark_mask);
        compare_field("three_charge", int'(want.charge), int'(three_charge));
        compare_field("total_spin_code", want.jcode, total_spin_code);
        compare_field("spin_code", want.scode, spin_code);
        compare_field("orbital_code", want.lcode, orbital_code);
        compare_field("fundamental_number", want.fund, fundamental_number);
        compare_field("extra_digits", want.extra, extra_digits);
        results_checked++;
        if (class_flags[FlagHadron]) hadrons_seen++;
        if (class_flags[FlagNucleus]) nuclei_seen++;
        if (class_flags[FlagLepton]) leptons_seen++;
      end
    end
  end

  initial begin
    #2ms;
    $display("%0t: timeout", $time);
    $display("tb_particle_code_classifier NOT OK");
    $finish;
  end

  initial begin : stimulus
    int waited;
    errors          = 0;
    requests_sent   = 0;
    results_checked = 0;
    hadrons_seen    = 0;
    nuclei_seen     = 0;
    leptons_seen    = 0;
    rst             = 1'b1;
    start           = 1'b0;
    particle_code   = '0;

    // extremes, leptons and the extra-digit codes
    add_known(32'd0,                 8'h00, 4'sd0,  14'd0,  8'd0);
    add_known(32'h8000_0000,         8'h40, 4'sd0,  14'd0,  8'd214);
    add_known(32'h7FFF_FFFF,         8'h40, 4'sd0,  14'd0,  8'd214);
    add_known(32'd11,                8'h21, -4'sd3, 14'd11, 8'd0);
    add_known(-32'sd11,              8'h21, 4'sd3,  14'd11, 8'd0);
    add_known(32'd450000000,         8'h41, 4'sd3,  14'd0,  8'd45);
    add_known(32'd480000000,         8'h01, 4'sd0,  14'd0,  8'd48);
    add_known(-32'sd470000000,       8'h41, 4'sd6,  14'd0,  8'd47);
    add_known(32'd500000000,         8'h01, 4'sd0,  14'd0,  8'd50);
    add_known(32'd510000000,         8'h40, 4'sd0,  14'd0,  8'd51);
    // mesons, baryons, diquarks and the spin/orbital corners
    add_predicted(32'd211);
    add_predicted(-32'sd211);
    add_predicted(32'd130);
    add_predicted(-32'sd310);
    add_predicted(32'd2212);
    add_predicted(-32'sd2212);
    add_predicted(32'd2203);
    add_predicted(32'd2201);
    add_predicted(-32'sd111);
    add_predicted(32'd9000211);
    add_predicted(32'd10113);
    add_predicted(32'd20213);
    add_predicted(32'd30223);
    add_predicted(32'd40113);
    add_predicted(32'd6);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      issue(directed_rows[i].code, directed_rows[i].res);
      if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 5));
    end

    for (int i = 0; i < RandomRequests; i++) begin : random_phase
      logic [31:0] code;
      code = random_code();
      issue(code, decode_code(code));
      // leave back-to-back stretches, and no gaps at all near the end
      if (i < RandomRequests - 150 && (i % 250) >= 50 && $urandom_range(0, 3) == 0) begin
        pause($urandom_range(1, 5));
      end
    end

    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    while (decode_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (decode_q.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0 pending, actual %0d",
               $time, decode_q.size(), decode_q.size());
      errors++;
    end
    repeat (FlushCycles) @(posedge clk);

    $display("Requests sent: %0d, results checked: %0d, mismatches: %0d",
             requests_sent, results_checked, errors);
    $display("Decoded %0d hadrons, %0d nuclei and %0d leptons among the results",
             hadrons_seen, nuclei_seen, leptons_seen);
    if (errors == 0) begin
      $display("tb_particle_code_classifier OK");
    end else begin
      $display("tb_particle_code_classifier NOT OK");
    end
    $finish;
  end

endmodule
